@@ hw/rtl/dosc_pkg.sv @@
// ----------------------------------------------------------------------------
// dosc_pkg
// Shared types, widths, microcode and helpers for the damped oscillator
// splitting step core.
// ----------------------------------------------------------------------------
package dosc_pkg;

	// widths
	localparam int unsigned DATA_W    = 32;
	localparam int unsigned OPND_W    = DATA_W + 1;
	localparam int unsigned PROD_W    = 2 * OPND_W;
	localparam int unsigned ENERGY_W  = DATA_W + 2;
	localparam int unsigned SUM_W     = 63;
	localparam int unsigned CFG_IDX_W = 3;
	localparam int unsigned UADDR_W   = 5;

	localparam logic [SUM_W-1:0]  SUM_MAX = '1;
	localparam logic [DATA_W-1:0] Q30_ONE = 32'h4000_0000;

	// item function codes
	localparam logic FUNC_LOAD = 1'b0;
	localparam logic FUNC_TICK = 1'b1;

	// configuration register indexes
	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_DAMP    = 3'd0,
		CFG_EGAIN   = 3'd1,
		CFG_HALF    = 3'd2,
		CFG_FULL    = 3'd3,
		CFG_SPRING  = 3'd4,
		CFG_THERMAL = 3'd5
	} cfg_idx_t;

	// multiplier operand sources
	typedef enum logic [3:0] {
		SRC_POS,
		SRC_MOM,
		SRC_ENT,
		SRC_TMP,
		SRC_MAG,
		SRC_DAMP,
		SRC_EGAIN,
		SRC_HALF,
		SRC_FULL,
		SRC_SPRING,
		SRC_THERMAL
	} src_t;

	// writeback destinations for the product of the previous step
	typedef enum logic [3:0] {
		WB_NONE,
		WB_E_SET,
		WB_E_ADD,
		WB_TMP,
		WB_MOM,
		WB_MOM_ADD,
		WB_POS_ADD,
		WB_ENT_ADD,
		WB_ACC
	} wb_t;

	// rounding shift applied to the product
	typedef enum logic [1:0] {
		SH_16,
		SH_17,
		SH_30,
		SH_31
	} sh_t;

	// sequencer control
	typedef enum logic [2:0] {
		CTL_NONE,
		CTL_MAG,
		CTL_BR_LOAD,
		CTL_END,
		CTL_START
	} ctl_t;

	// one control word
	typedef struct packed {
		logic               issue;
		src_t               a;
		src_t               b;
		wb_t                wb;
		sh_t                sh;
		logic               neg;
		ctl_t               ctl;
		logic [UADDR_W-1:0] target;
	} ucode_t;

	localparam logic [UADDR_W-1:0] ADDR_LOAD_END = 5'd21;

	function automatic ucode_t uop(input logic issue, input src_t a, input src_t b,
		input wb_t wb, input sh_t sh, input logic neg, input ctl_t ctl,
		input logic [UADDR_W-1:0] target);
		ucode_t w;
		w.issue  = issue;
		w.a      = a;
		w.b      = b;
		w.wb     = wb;
		w.sh     = sh;
		w.neg    = neg;
		w.ctl    = ctl;
		w.target = target;
		return w;
	endfunction

	// microprogram: energy prefix shared by load and tick, then the tick body;
	// a load branches from the end of the prefix to its own final word
	function automatic ucode_t ucode(input logic [UADDR_W-1:0] addr);
		ucode_t w;
		unique case (addr)
			// kinetic, potential and thermal terms of the energy
			5'd0:  w = uop(1'b1, SRC_MOM, SRC_MOM,     WB_NONE,    SH_16, 1'b0, CTL_NONE, '0);
			5'd1:  w = uop(1'b1, SRC_POS, SRC_POS,     WB_E_SET,   SH_17, 1'b0, CTL_NONE, '0);
			5'd2:  w = uop(1'b1, SRC_ENT, SRC_THERMAL, WB_TMP,     SH_16, 1'b0, CTL_NONE, '0);
			5'd3:  w = uop(1'b1, SRC_TMP, SRC_SPRING,  WB_E_ADD,   SH_30, 1'b0, CTL_NONE, '0);
			5'd4:  w = uop(1'b1, SRC_MOM, SRC_MOM,     WB_E_ADD,   SH_31, 1'b0, CTL_BR_LOAD,
				ADDR_LOAD_END);
			// first half damping, drift magnitude
			5'd5:  w = uop(1'b1, SRC_MOM, SRC_DAMP,    WB_TMP,     SH_16, 1'b0, CTL_MAG,  '0);
			5'd6:  w = uop(1'b1, SRC_TMP, SRC_EGAIN,   WB_MOM,     SH_30, 1'b0, CTL_NONE, '0);
			5'd7:  w = uop(1'b1, SRC_POS, SRC_SPRING,  WB_ENT_ADD, SH_30, 1'b0, CTL_NONE, '0);
			// first force, squared drift, half kick
			5'd8:  w = uop(1'b1, SRC_MAG, SRC_MAG,     WB_TMP,     SH_30, 1'b1, CTL_NONE, '0);
			5'd9:  w = uop(1'b1, SRC_TMP, SRC_HALF,    WB_ACC,     SH_30, 1'b0, CTL_NONE, '0);
			5'd10: w = uop(1'b0, SRC_POS, SRC_POS,     WB_MOM_ADD, SH_30, 1'b0, CTL_NONE, '0);
			// drift of position
			5'd11: w = uop(1'b1, SRC_MOM, SRC_FULL,    WB_NONE,    SH_30, 1'b0, CTL_NONE, '0);
			5'd12: w = uop(1'b0, SRC_POS, SRC_POS,     WB_POS_ADD, SH_30, 1'b0, CTL_NONE, '0);
			// second force and half kick
			5'd13: w = uop(1'b1, SRC_POS, SRC_SPRING,  WB_NONE,    SH_30, 1'b0, CTL_NONE, '0);
			5'd14: w = uop(1'b0, SRC_POS, SRC_POS,     WB_TMP,     SH_30, 1'b1, CTL_NONE, '0);
			5'd15: w = uop(1'b1, SRC_TMP, SRC_HALF,    WB_NONE,    SH_30, 1'b0, CTL_NONE, '0);
			5'd16: w = uop(1'b0, SRC_POS, SRC_POS,     WB_MOM_ADD, SH_30, 1'b0, CTL_NONE, '0);
			// second half damping
			5'd17: w = uop(1'b1, SRC_MOM, SRC_MOM,     WB_NONE,    SH_16, 1'b0, CTL_NONE, '0);
			5'd18: w = uop(1'b1, SRC_MOM, SRC_DAMP,    WB_TMP,     SH_16, 1'b0, CTL_NONE, '0);
			5'd19: w = uop(1'b1, SRC_TMP, SRC_EGAIN,   WB_MOM,     SH_30, 1'b0, CTL_NONE, '0);
			5'd20: w = uop(1'b0, SRC_POS, SRC_POS,     WB_ENT_ADD, SH_30, 1'b0, CTL_END,  '0);
			// load: keep the start energy
			5'd21: w = uop(1'b0, SRC_POS, SRC_POS,     WB_NONE,    SH_30, 1'b0, CTL_START, '0);
			default: w = uop(1'b0, SRC_POS, SRC_POS,   WB_NONE,    SH_30, 1'b0, CTL_END,  '0);
		endcase
		return w;
	endfunction

	// clamp to the signed 32 bit range
	function automatic logic signed [DATA_W-1:0] sat32(input logic signed [PROD_W-1:0] v);
		logic signed [DATA_W-1:0] r;
		if (&v[PROD_W-1:DATA_W-1] || ~|v[PROD_W-1:DATA_W-1]) begin
			r = v[DATA_W-1:0];
		end else if (v[PROD_W-1]) begin
			r = 32'sh8000_0000;
		end else begin
			r = 32'sh7fff_ffff;
		end
		return r;
	endfunction

endpackage

@@ hw/rtl/damped_oscillator_splitting_step_core.sv @@
// ----------------------------------------------------------------------------
// damped_oscillator_splitting_step_core
// One damping-Verlet-damping step of a 1-D damped oscillator with entropy
// and a saturating sum of squared energy drift, run by a microcoded sequencer
// around one shared 33x33 multiplier.
// ----------------------------------------------------------------------------
//  channel | direction | handshake                 | payload
//  --------+-----------+---------------------------+---------------------------------
//  in      | input     | in_valid / in_stall       | func, init_position/momentum/entropy
//  out     | output    | out_valid / out_stall     | position, momentum, entropy,
//          |           |                           | drift_square_sum, sum_saturated
//  cfg     | input     | cfg_write_en (no wait)    | cfg_index, cfg_data
//
//  a tick runs 21 microcode steps and a load runs 6; the result is then registered
//  from the done state once the output slot is free
//  the step count is set by the single multiplier and the dependent chain of products
//  one item at a time; in_stall is high from the transfer until the result is
//  registered, and the result waits there while out_stall is high
//  reset clears state and out_valid and sets configuration defaults; no clearing pass
// ----------------------------------------------------------------------------
module damped_oscillator_splitting_step_core
	import dosc_pkg::*;
(
	input  logic                     clk,
	input  logic                     arst_n,
	// configuration
	input  logic                     cfg_write_en,
	input  logic [CFG_IDX_W-1:0]     cfg_index,
	input  logic [DATA_W-1:0]        cfg_data,
	// input channel
	input  logic                     in_valid,
	output logic                     in_stall,
	input  logic                     func,
	input  logic signed [DATA_W-1:0] init_position,
	input  logic signed [DATA_W-1:0] init_momentum,
	input  logic signed [DATA_W-1:0] init_entropy,
	// output channel
	output logic                     out_valid,
	input  logic                     out_stall,
	output logic signed [DATA_W-1:0] position,
	output logic signed [DATA_W-1:0] momentum,
	output logic signed [DATA_W-1:0] entropy,
	output logic [SUM_W-1:0]         drift_square_sum,
	output logic                     sum_saturated
);

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_RUN,
		ST_DONE
	} state_t;

	state_t               state_q;
	logic [UADDR_W-1:0]   step_q;
	logic                 load_q;
	logic                 out_valid_q;
	logic signed [DATA_W-1:0] position_q, momentum_q, entropy_q;
	logic [SUM_W-1:0]     sum_q;
	logic                 sat_q;

	// configuration registers
	logic [DATA_W-1:0] damp_q, egain_q, half_q, full_q, spring_q, thermal_q;

	// datapath state
	logic signed [DATA_W-1:0]   pos_q, mom_q, ent_q, start_q, tmp_q;
	logic signed [ENERGY_W-1:0] energy_q;
	logic [DATA_W-1:0]          mag_q;
	logic [SUM_W-1:0]           acc_q;
	logic signed [PROD_W-1:0]   prod_s1;

	ucode_t uw;
	logic   run;
	logic   in_xfer;
	logic   slot_free;
	logic   done_step;

	logic signed [OPND_W-1:0]   op_a, op_b;
	logic signed [PROD_W-1:0]   rounded;
	logic signed [PROD_W-1:0]   shaped;
	logic signed [DATA_W-1:0]   res;
	logic signed [DATA_W-1:0]   mom_sum, pos_sum, ent_sum;
	logic signed [DATA_W-1:0]   energy_sat;
	logic signed [DATA_W:0]     drift;
	logic signed [DATA_W:0]     drift_abs;
	logic [SUM_W+1:0]           acc_sum;
	logic [SUM_W-1:0]           acc_next;

	// handshake
	assign uw        = ucode(step_q);
	assign run       = (state_q == ST_RUN);
	assign in_stall  = (state_q != ST_IDLE);
	assign in_xfer   = in_valid && (state_q == ST_IDLE);
	assign slot_free = !out_valid_q || !out_stall;
	assign done_step = run && (uw.ctl == CTL_END || uw.ctl == CTL_START);

	assign out_valid        = out_valid_q;
	assign position         = position_q;
	assign momentum         = momentum_q;
	assign entropy          = entropy_q;
	assign drift_square_sum = sum_q;
	assign sum_saturated    = sat_q;

	// configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			damp_q    <= Q30_ONE;
			egain_q   <= '0;
			half_q    <= '0;
			full_q    <= '0;
			spring_q  <= Q30_ONE;
			thermal_q <= Q30_ONE;
		end else if (cfg_write_en) begin
			unique case (cfg_idx_t'(cfg_index))
				CFG_DAMP:    damp_q    <= cfg_data;
				CFG_EGAIN:   egain_q   <= cfg_data;
				CFG_HALF:    half_q    <= cfg_data;
				CFG_FULL:    full_q    <= cfg_data;
				CFG_SPRING:  spring_q  <= cfg_data;
				CFG_THERMAL: thermal_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// operand selection
	function automatic logic signed [OPND_W-1:0] operand(input src_t s);
		logic signed [OPND_W-1:0] v;
		unique case (s)
			SRC_POS:     v = OPND_W'(pos_q);
			SRC_MOM:     v = OPND_W'(mom_q);
			SRC_ENT:     v = OPND_W'(ent_q);
			SRC_TMP:     v = OPND_W'(tmp_q);
			SRC_MAG:     v = {1'b0, mag_q};
			SRC_DAMP:    v = {1'b0, damp_q};
			SRC_EGAIN:   v = {1'b0, egain_q};
			SRC_HALF:    v = {1'b0, half_q};
			SRC_FULL:    v = {1'b0, full_q};
			SRC_SPRING:  v = {1'b0, spring_q};
			SRC_THERMAL: v = {1'b0, thermal_q};
			default:     v = '0;
		endcase
		return v;
	endfunction

	always_comb begin
		op_a = operand(uw.a);
		op_b = operand(uw.b);
	end

	// round half up, optional negation, clamp
	always_comb begin
		unique case (uw.sh)
			SH_16: rounded = (prod_s1 + (PROD_W'(1) <<< 15)) >>> 16;
			SH_17: rounded = (prod_s1 + (PROD_W'(1) <<< 16)) >>> 17;
			SH_30: rounded = (prod_s1 + (PROD_W'(1) <<< 29)) >>> 30;
			SH_31: rounded = (prod_s1 + (PROD_W'(1) <<< 30)) >>> 31;
			default: rounded = '0;
		endcase
		shaped = uw.neg ? -rounded : rounded;
		res    = sat32(shaped);
	end

	// saturating state updates
	assign mom_sum = sat32(PROD_W'(mom_q) + PROD_W'(res));
	assign pos_sum = sat32(PROD_W'(pos_q) + PROD_W'(res));
	assign ent_sum = sat32(PROD_W'(ent_q) + PROD_W'(res));

	// energy drift magnitude
	assign energy_sat = sat32(PROD_W'(energy_q));
	assign drift      = (DATA_W+1)'(energy_sat) - (DATA_W+1)'(start_q);
	assign drift_abs  = drift[DATA_W] ? -drift : drift;

	// drift sum, stops at its maximum
	assign acc_sum  = {2'b00, acc_q} + {1'b0, prod_s1[SUM_W:0]};
	assign acc_next = (acc_sum >= {2'b00, SUM_MAX}) ? SUM_MAX : acc_sum[SUM_W-1:0];

	// shared multiplier
	always_ff @(posedge clk) begin
		if (run && uw.issue) begin
			prod_s1 <= op_a * op_b;
		end
	end

	// scratch registers
	always_ff @(posedge clk) begin
		if (run) begin
			unique case (uw.wb)
				WB_E_SET: energy_q <= ENERGY_W'(res);
				WB_E_ADD: energy_q <= energy_q + ENERGY_W'(res);
				WB_TMP:   tmp_q    <= res;
				default: ;
			endcase
			if (uw.ctl == CTL_MAG) begin
				mag_q <= drift_abs[DATA_W-1:0];
			end
		end
	end

	// oscillator state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q   <= '0;
			mom_q   <= '0;
			ent_q   <= '0;
			start_q <= '0;
			acc_q   <= '0;
		end else if (in_xfer && func == FUNC_LOAD) begin
			pos_q <= init_position;
			mom_q <= init_momentum;
			ent_q <= init_entropy;
			acc_q <= '0;
		end else if (run) begin
			unique case (uw.wb)
				WB_MOM:     mom_q <= res;
				WB_MOM_ADD: mom_q <= mom_sum;
				WB_POS_ADD: pos_q <= pos_sum;
				WB_ENT_ADD: ent_q <= ent_sum;
				WB_ACC:     acc_q <= acc_next;
				default: ;
			endcase
			if (uw.ctl == CTL_START) begin
				start_q <= energy_sat;
			end
		end
	end

	// sequencer and output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			step_q      <= '0;
			load_q      <= 1'b0;
			out_valid_q <= 1'b0;
			position_q  <= '0;
			momentum_q  <= '0;
			entropy_q   <= '0;
			sum_q       <= '0;
			sat_q       <= 1'b0;
		end else begin
			// the finishing state refills the slot itself
			if (state_q != ST_DONE && out_valid_q && !out_stall) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (in_valid) begin
						state_q <= ST_RUN;
						step_q  <= '0;
						load_q  <= (func == FUNC_LOAD);
					end
				end
				ST_RUN: begin
					if (done_step) begin
						state_q <= ST_DONE;
					end else if (uw.ctl == CTL_BR_LOAD && load_q) begin
						step_q <= uw.target;
					end else begin
						step_q <= step_q + 1'b1;
					end
				end
				ST_DONE: begin
					if (slot_free) begin
						state_q     <= ST_IDLE;
						out_valid_q <= 1'b1;
						position_q  <= pos_q;
						momentum_q  <= mom_q;
						entropy_q   <= ent_q;
						sum_q       <= acc_q;
						sat_q       <= (acc_q == SUM_MAX);
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

endmodule

@@ hw/rtl/dosc_checker.sv @@
// ----------------------------------------------------------------------------
// dosc_checker
// Port-level checks on the damped oscillator splitting step core, attached
// by a bind statement.
// ----------------------------------------------------------------------------
module dosc_checker
	import dosc_pkg::*;
(
	input logic                     clk,
	input logic                     arst_n,
	input logic                     in_valid,
	input logic                     in_stall,
	input logic                     out_valid,
	input logic                     out_stall,
	input logic signed [DATA_W-1:0] position,
	input logic signed [DATA_W-1:0] momentum,
	input logic signed [DATA_W-1:0] entropy,
	input logic [SUM_W-1:0]         drift_square_sum,
	input logic                     sum_saturated
);

	// the core stays busy after an input transfer
	a_busy_after_transfer: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |=> in_stall ##1 in_stall)
		else $error("input accepted too soon after a transfer");

	// saturation flag agrees with the sum
	a_sat_flag: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> sum_saturated == (drift_square_sum == SUM_MAX))
		else $error("saturation flag does not match drift sum");

	// a fresh result leaves the core ready for the next item
	a_ready_with_result: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> !in_stall)
		else $error("core still busy when a new result appears");

	// a stalled result holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(position) && $stable(momentum)
			&& $stable(entropy) && $stable(drift_square_sum))
		else $error("stalled result changed");

endmodule

bind damped_oscillator_splitting_step_core dosc_checker u_dosc_checker (.*);
